// ===== rtl/tcce_pkg.sv =====
package tcce_pkg;

    localparam int TCCE_SCREEN_COLUMNS = 80;
    localparam int TCCE_SCREEN_ROWS    = 25;
    localparam int TCCE_CONSOLE_COUNT  = 3;
    localparam int TCCE_CONSOLE_CELLS  = 4000;

    // Region row index (up to 1024 lines) and column index (up to 256 columns)
    localparam int ROW_W  = 10;
    localparam int COL_W  = 8;
    localparam int ADDR_W = 14;

    localparam logic [1:0] ACT_PUT  = 2'd0;
    localparam logic [1:0] ACT_UP   = 2'd1;
    localparam logic [1:0] ACT_DOWN = 2'd2;

    localparam logic [7:0] CH_NEWLINE   = 8'd10;
    localparam logic [7:0] CH_BACKSPACE = 8'd8;
    localparam logic [7:0] CH_SPACE     = 8'd32;

    localparam logic [7:0] ATTR_RESET = 8'd7;

    typedef struct packed {
        logic [1:0] action;
        logic [1:0] console_id;
        logic [7:0] character;
    } t_cmd;

    typedef struct packed {
        logic              vram_write;
        logic [ADDR_W-1:0] vram_address;
        logic [7:0]        vram_char;
        logic [7:0]        vram_attr;
        logic [ADDR_W-1:0] cursor_position;
        logic [ADDR_W-1:0] display_start;
    } t_res;

    // Per-console state, kept as offsets from the region origin
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] wrow;
    } t_con_state;

    typedef struct packed {
        logic             wr_en;
        logic [ROW_W-1:0] wr_row;
        logic [COL_W-1:0] wr_col;
        logic [7:0]       wr_char;
        t_con_state       nxt;
    } t_upd;

    typedef struct packed {
        logic       in_range;
        logic [1:0] id;
        t_upd       upd;
    } t_s2;

endpackage

// ===== rtl/tcce_stream_if.sv =====
interface tcce_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/tcce_state_mem.sv =====
module tcce_state_mem import tcce_pkg::*; #(
    parameter int CONSOLE_COUNT = TCCE_CONSOLE_COUNT,
    localparam int IW = (CONSOLE_COUNT > 1) ? $clog2(CONSOLE_COUNT) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rd_en,
    input  logic [IW-1:0] i_rd_idx,
    output t_con_state    o_rd_data,
    input  logic          i_wr_en,
    input  logic [IW-1:0] i_wr_idx,
    input  t_con_state    i_wr_data
);

    t_con_state               r_mem [CONSOLE_COUNT];
    logic [CONSOLE_COUNT-1:0] r_valid;
    t_con_state               r_rd_data;
    logic                     r_rd_valid;
    logic                     same_entry;

    assign same_entry = i_wr_en && (i_wr_idx == i_rd_idx);

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_data;
        end
        // forward a write that lands on the entry being read
        if (i_rd_en) begin
            r_rd_data <= same_entry ? i_wr_data : r_mem[i_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_idx] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= same_entry || r_valid[i_rd_idx];
            end
        end
    end

    // unwritten entry reads as the region origin
    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

// ===== rtl/tcce_update.sv =====
module tcce_update import tcce_pkg::*; #(
    parameter int SCREEN_COLUMNS = TCCE_SCREEN_COLUMNS,
    parameter int SCREEN_ROWS    = TCCE_SCREEN_ROWS,
    parameter int CONSOLE_CELLS  = TCCE_CONSOLE_CELLS
) (
    input  logic [1:0] i_action,
    input  logic [7:0] i_char,
    input  t_con_state i_st,
    output t_upd       o_upd
);

    localparam int LINES = CONSOLE_CELLS / SCREEN_COLUMNS;
    localparam int SW    = ROW_W + 1;

    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(LINES - 1);
    localparam logic [COL_W-1:0] LAST_COL = COL_W'(SCREEN_COLUMNS - 1);
    localparam logic [SW-1:0]    ROWS_C   = SW'(SCREEN_ROWS);
    localparam logic [SW-1:0]    LINES_C  = SW'(LINES);
    localparam logic [SW-1:0]    TOP_WIN  = SW'(LINES - SCREEN_ROWS);

    logic [SW-1:0] win_end;
    logic [SW-1:0] nrow;
    logic [SW-1:0] tgt;

    assign win_end = {1'b0, i_st.wrow} + ROWS_C;

    always_comb begin
        o_upd     = '0;
        o_upd.nxt = i_st;
        nrow      = '0;
        tgt       = '0;
        case (i_action)
            ACT_PUT: begin
                if (i_char == CH_NEWLINE) begin
                    if (i_st.row != LAST_ROW) begin
                        o_upd.nxt.row = i_st.row + ROW_W'(1);
                        o_upd.nxt.col = '0;
                    end
                end else if (i_char == CH_BACKSPACE) begin
                    if (i_st.row != '0 || i_st.col != '0) begin
                        if (i_st.col != '0) begin
                            o_upd.nxt.col = i_st.col - COL_W'(1);
                        end else begin
                            o_upd.nxt.row = i_st.row - ROW_W'(1);
                            o_upd.nxt.col = LAST_COL;
                        end
                        o_upd.wr_en   = 1'b1;
                        o_upd.wr_row  = o_upd.nxt.row;
                        o_upd.wr_col  = o_upd.nxt.col;
                        o_upd.wr_char = CH_SPACE;
                    end
                end else begin
                    if (!(i_st.row == LAST_ROW && i_st.col == LAST_COL)) begin
                        o_upd.wr_en   = 1'b1;
                        o_upd.wr_row  = i_st.row;
                        o_upd.wr_col  = i_st.col;
                        o_upd.wr_char = i_char;
                        if (i_st.col == LAST_COL) begin
                            o_upd.nxt.row = i_st.row + ROW_W'(1);
                            o_upd.nxt.col = '0;
                        end else begin
                            o_upd.nxt.col = i_st.col + COL_W'(1);
                        end
                    end
                end
                // pull the window down until the cursor line is its last line
                nrow = {1'b0, o_upd.nxt.row};
                if (nrow >= win_end && win_end < LINES_C) begin
                    tgt = nrow - ROWS_C + SW'(1);
                    o_upd.nxt.wrow = ROW_W'((tgt < TOP_WIN) ? tgt : TOP_WIN);
                end
            end
            ACT_UP: begin
                if (i_st.wrow != '0) begin
                    o_upd.nxt.wrow = i_st.wrow - ROW_W'(1);
                end
            end
            ACT_DOWN: begin
                if (win_end < LINES_C) begin
                    o_upd.nxt.wrow = i_st.wrow + ROW_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== rtl/tcce_out_stage.sv =====
module tcce_out_stage import tcce_pkg::*; #(
    parameter int SCREEN_COLUMNS = TCCE_SCREEN_COLUMNS,
    parameter int CONSOLE_CELLS  = TCCE_CONSOLE_CELLS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  t_s2            i_s2,
    input  logic [7:0]     i_attr,
    output logic           o_free,
    tcce_stream_if.source  o_res
);

    // wide enough for the highest absolute cell of the last console
    localparam int AW = 17;

    logic [AW-1:0] origin;
    logic [AW-1:0] cur_addr;
    logic [AW-1:0] win_addr;
    logic [AW-1:0] wr_addr;
    t_res          n_res;
    t_res          r_res;
    logic          r_ov;

    assign origin   = AW'(i_s2.id) * AW'(CONSOLE_CELLS);
    assign cur_addr = origin + AW'(i_s2.upd.nxt.row) * AW'(SCREEN_COLUMNS)
                      + AW'(i_s2.upd.nxt.col);
    assign win_addr = origin + AW'(i_s2.upd.nxt.wrow) * AW'(SCREEN_COLUMNS);
    assign wr_addr  = origin + AW'(i_s2.upd.wr_row) * AW'(SCREEN_COLUMNS)
                      + AW'(i_s2.upd.wr_col);

    always_comb begin
        n_res = '0;
        if (i_s2.in_range) begin
            n_res.cursor_position = cur_addr[ADDR_W-1:0];
            n_res.display_start   = win_addr[ADDR_W-1:0];
            if (i_s2.upd.wr_en) begin
                n_res.vram_write   = 1'b1;
                n_res.vram_address = wr_addr[ADDR_W-1:0];
                n_res.vram_char    = i_s2.upd.wr_char;
                n_res.vram_attr    = i_attr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_load) begin
            r_ov <= 1'b1;
        end else if (o_res.ready) begin
            r_ov <= 1'b0;
        end
    end

    assign o_free      = !r_ov || o_res.ready;
    assign o_res.valid = r_ov;
    assign o_res.data  = r_res;

endmodule

// ===== rtl/text_console_cursor_engine.sv =====
// Throughput: one command per cycle unless the output stalls; the console
// state memory is read at acceptance and written back as stage 1 advances,
// with a write-to-read bypass. Reset (synchronous, active low) empties
// the pipeline, sets the attribute to 7 and marks every console entry
// unwritten, so it reads as its origin.
module text_console_cursor_engine import tcce_pkg::*; #(
    parameter int SCREEN_COLUMNS = TCCE_SCREEN_COLUMNS,
    parameter int SCREEN_ROWS    = TCCE_SCREEN_ROWS,
    parameter int CONSOLE_COUNT  = TCCE_CONSOLE_COUNT,
    parameter int CONSOLE_CELLS  = TCCE_CONSOLE_CELLS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tcce_stream_if.sink   i_cmd,
    tcce_stream_if.sink   i_cfg,
    tcce_stream_if.source o_res
);

    localparam int IW = (CONSOLE_COUNT > 1) ? $clog2(CONSOLE_COUNT) : 1;

    logic [7:0] r_attr;
    logic       r_s1v;
    logic [1:0] r_s1_action;
    logic [1:0] r_s1_id;
    logic [7:0] r_s1_char;
    logic       r_s1_inr;

    logic       cmd_inr;
    logic       accept;
    logic       out_free;
    logic       s1_adv;
    t_con_state rd_state;
    t_upd       upd;
    t_s2        s2;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= ATTR_RESET;
        end else if (i_cfg.valid) begin
            r_attr <= i_cfg.data;
        end
    end

    assign cmd_inr     = {2'b00, i_cmd.data.console_id} < 4'(CONSOLE_COUNT);
    assign s1_adv      = r_s1v && out_free;
    assign i_cmd.ready = !r_s1v || out_free;
    assign accept      = i_cmd.valid && i_cmd.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1v <= 1'b0;
        end else if (accept) begin
            r_s1v <= 1'b1;
        end else if (s1_adv) begin
            r_s1v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_action <= i_cmd.data.action;
            r_s1_id     <= i_cmd.data.console_id;
            r_s1_char   <= i_cmd.data.character;
            r_s1_inr    <= cmd_inr;
        end
    end

    tcce_state_mem #(
        .CONSOLE_COUNT(CONSOLE_COUNT)
    ) u_mem (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_en  (accept && cmd_inr),
        .i_rd_idx (IW'(i_cmd.data.console_id)),
        .o_rd_data(rd_state),
        .i_wr_en  (s1_adv && r_s1_inr),
        .i_wr_idx (IW'(r_s1_id)),
        .i_wr_data(upd.nxt)
    );

    tcce_update #(
        .SCREEN_COLUMNS(SCREEN_COLUMNS),
        .SCREEN_ROWS   (SCREEN_ROWS),
        .CONSOLE_CELLS (CONSOLE_CELLS)
    ) u_update (
        .i_action(r_s1_action),
        .i_char  (r_s1_char),
        .i_st    (rd_state),
        .o_upd   (upd)
    );

    assign s2.in_range = r_s1_inr;
    assign s2.id       = r_s1_id;
    assign s2.upd      = upd;

    tcce_out_stage #(
        .SCREEN_COLUMNS(SCREEN_COLUMNS),
        .CONSOLE_CELLS (CONSOLE_CELLS)
    ) u_out (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_load (s1_adv),
        .i_s2   (s2),
        .i_attr (r_attr),
        .o_free (out_free),
        .o_res  (o_res)
    );

endmodule

// ===== rtl/tcce_checker.sv =====
module tcce_checker import tcce_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_res_valid,
    input logic i_res_ready,
    input t_res i_res_data
);

    // no result may appear right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_data))
        else $error("stalled result changed");

    // a written cell is the new cursor (backspace) or the cell just before it
    a_write_near_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_res_data.vram_write |->
            i_res_data.cursor_position == i_res_data.vram_address ||
            i_res_data.cursor_position == i_res_data.vram_address + ADDR_W'(1))
        else $error("write address does not match cursor");

    a_idle_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_data.vram_write |->
            i_res_data.vram_address == '0 && i_res_data.vram_char == '0 &&
            i_res_data.vram_attr == '0)
        else $error("write fields not cleared without a write");

endmodule

bind text_console_cursor_engine tcce_checker u_tcce_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_res_valid(o_res.valid),
    .i_res_ready(o_res.ready),
    .i_res_data (o_res.data)
);

// ===== dv/text_console_cursor_engine_tb.sv =====
`timescale 1ns / 1ps

module text_console_cursor_engine_tb;
    import tcce_pkg::*;

    localparam int COLS        = TCCE_SCREEN_COLUMNS;
    localparam int SCREEN      = TCCE_SCREEN_COLUMNS * TCCE_SCREEN_ROWS;
    localparam int CONSOLES    = TCCE_CONSOLE_COUNT;
    localparam int REGION      = TCCE_CONSOLE_CELLS;
    localparam int CYCLE_LIMIT = 200000;
    localparam int ITEMS_PER_PHASE = 130;
    localparam int HOLD_AT     = 150;
    localparam int HOLD_CYCLES = 120;

    logic i_clk;
    logic i_rst_n;

    tcce_stream_if #(.T(t_cmd))       cmd_if ();
    tcce_stream_if #(.T(logic [7:0])) cfg_if ();
    tcce_stream_if #(.T(t_res))       res_if ();

    text_console_cursor_engine u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .i_cfg   (cfg_if),
        .o_res   (res_if)
    );

    // Console model state
    int         cursor_at [CONSOLES];
    int         window_at [CONSOLES];
    logic [7:0] attr_now;

    t_cmd pend_cmds [$];
    t_res want_res  [$];

    int   errors;
    int   cycle_cnt;
    int   res_seen;
    int   hold_left;
    bit   hold_done;
    bit   calm;
    bit   cmd_taken;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_res console_update(t_cmd c);
        t_res r;
        int   id;
        int   origin;
        int   limit;
        int   off;
        int   k;
        r = '0;
        id = int'(c.console_id);
        if (id >= CONSOLES)
            return r;
        origin = id * REGION;
        limit  = origin + REGION;
        case (c.action)
            ACT_PUT: begin
                off = cursor_at[id] - origin;
                if (c.character == CH_NEWLINE) begin
                    if (cursor_at[id] + COLS < limit)
                        cursor_at[id] = origin + COLS * (off / COLS + 1);
                end else if (c.character == CH_BACKSPACE) begin
                    if (cursor_at[id] > origin) begin
                        cursor_at[id]--;
                        r.vram_write   = 1'b1;
                        r.vram_address = cursor_at[id][ADDR_W-1:0];
                        r.vram_char    = CH_SPACE;
                        r.vram_attr    = attr_now;
                    end
                end else if (cursor_at[id] + 1 < limit) begin
                    r.vram_write   = 1'b1;
                    r.vram_address = cursor_at[id][ADDR_W-1:0];
                    r.vram_char    = c.character;
                    r.vram_attr    = attr_now;
                    cursor_at[id]++;
                end
                // Follow the cursor down, possibly several lines at once
                for (k = 0; k <= REGION / COLS; k++) begin
                    if (cursor_at[id] < window_at[id] + SCREEN)
                        break;
                    if (window_at[id] + SCREEN >= limit)
                        break;
                    window_at[id] += COLS;
                end
            end
            ACT_UP: begin
                if (window_at[id] > origin)
                    window_at[id] -= COLS;
            end
            ACT_DOWN: begin
                if (window_at[id] + SCREEN < limit)
                    window_at[id] += COLS;
            end
            default: ;
        endcase
        r.cursor_position = cursor_at[id][ADDR_W-1:0];
        r.display_start   = window_at[id][ADDR_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_cnt);
        errors++;
    endtask

    task automatic check_field(string what, int got, int want);
        if (got != want)
            report_mismatch(what, got, want);
    endtask

    // Input side: predict on every accepted command, track attribute writes
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
        cmd_taken = 1'b0;
        if (i_rst_n) begin
            if (cmd_if.valid && cmd_if.ready) begin
                cmd_taken = 1'b1;
                want_res.push_back(console_update(cmd_if.data));
            end
            if (cfg_if.valid && cfg_if.ready)
                attr_now = cfg_if.data;
        end
    end

    // Output side: compare against the oldest expectation
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            res_seen++;
            if (want_res.size() == 0) begin
                report_mismatch("unexpected result transaction", 1, 0);
            end else begin
                want = want_res.pop_front();
                check_field("vram_write", res_if.data.vram_write, want.vram_write);
                check_field("vram_address", res_if.data.vram_address, want.vram_address);
                check_field("vram_char", res_if.data.vram_char, want.vram_char);
                check_field("vram_attr", res_if.data.vram_attr, want.vram_attr);
                check_field("cursor_position", res_if.data.cursor_position,
                            want.cursor_position);
                check_field("display_start", res_if.data.display_start,
                            want.display_start);
            end
        end
    end

    // Command driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
        end else if (!cmd_if.valid || cmd_taken) begin
            if (pend_cmds.size() != 0 && (calm || $urandom_range(0, 99) >= 10)) begin
                cmd_if.data  <= pend_cmds.pop_front();
                cmd_if.valid <= 1'b1;
            end else begin
                cmd_if.valid <= 1'b0;
            end
        end
    end

    // Result receiver, with one long hold-off so the pipeline backs up
    always @(negedge i_clk) begin
        if (!hold_done && res_seen >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= calm || ($urandom_range(0, 99) >= 10);
        end
    end

    task automatic push_cmd(logic [1:0] act, logic [1:0] id, logic [7:0] ch);
        t_cmd c;
        c.action     = act;
        c.console_id = id;
        c.character  = ch;
        pend_cmds.push_back(c);
    endtask

    task automatic wait_drained();
        while (pend_cmds.size() != 0 || cmd_if.valid || want_res.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_attr(logic [7:0] value);
        @(negedge i_clk);
        cfg_if.data  <= value;
        cfg_if.valid <= 1'b1;
        @(posedge i_clk);
        while (!cfg_if.ready)
            @(posedge i_clk);
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // One random stretch of commands built from well-formed runs plus noise
    task automatic run_phase(logic [7:0] attr, bit quiet);
        int pushed;
        int kind;
        int len;
        int ups;
        int i;
        logic [1:0] id;
        wait_drained();
        write_attr(attr);
        calm = quiet;
        pushed = 0;
        while (pushed < ITEMS_PER_PHASE) begin
            kind = $urandom_range(0, 9);
            id   = 2'($urandom_range(0, CONSOLES - 1));
            case (kind)
                0, 1: begin
                    len = $urandom_range(1, 20);
                    for (i = 0; i < len; i++) push_cmd(ACT_PUT, id, CH_NEWLINE);
                end
                2, 3: begin
                    len = $urandom_range(1, 40);
                    for (i = 0; i < len; i++)
                        push_cmd(ACT_PUT, id, 8'($urandom_range(0, 255)));
                end
                4: begin
                    len = $urandom_range(1, 30);
                    for (i = 0; i < len; i++) push_cmd(ACT_PUT, id, CH_BACKSPACE);
                end
                5: begin
                    len = $urandom_range(1, 25);
                    for (i = 0; i < len; i++) push_cmd(ACT_UP, id, 8'($urandom));
                end
                6: begin
                    len = $urandom_range(1, 25);
                    for (i = 0; i < len; i++) push_cmd(ACT_DOWN, id, 8'($urandom));
                end
                7: begin
                    // march to the last cell, pull the window back, then print
                    len = REGION / COLS;
                    for (i = 0; i < len; i++) push_cmd(ACT_PUT, id, CH_NEWLINE);
                    for (i = 0; i < COLS + 5; i++)
                        push_cmd(ACT_PUT, id, 8'($urandom_range(32, 126)));
                    ups = int'($urandom_range(0, 30));
                    for (i = 0; i < ups; i++)
                        push_cmd(ACT_UP, id, 8'h00);
                    push_cmd(ACT_PUT, id, 8'($urandom_range(32, 126)));
                    len = len + COLS + 6 + ups;
                end
                8: begin
                    len = $urandom_range(1, 30);
                    for (i = 0; i < len; i++) push_cmd(ACT_UP, id, 8'h00);
                    push_cmd(ACT_PUT, id, 8'($urandom_range(0, 255)));
                    len++;
                end
                default: begin
                    len = $urandom_range(1, 10);
                    for (i = 0; i < len; i++)
                        push_cmd(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                                 8'($urandom_range(0, 255)));
                end
            endcase
            pushed += len;
        end
    endtask

    initial begin
        errors       = 0;
        cycle_cnt    = 0;
        res_seen     = 0;
        hold_left    = 0;
        hold_done    = 1'b0;
        calm         = 1'b0;
        cmd_taken    = 1'b0;
        attr_now     = ATTR_RESET;
        for (int c = 0; c < CONSOLES; c++) begin
            cursor_at[c] = c * REGION;
            window_at[c] = c * REGION;
        end
        i_rst_n      = 1'b0;
        cmd_if.valid = 1'b0;
        cmd_if.data  = '0;
        cfg_if.valid = 1'b0;
        cfg_if.data  = '0;
        res_if.ready = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: reset attribute, byte extremes, edges, unused codes
        push_cmd(ACT_PUT, 2'd0, 8'h00);
        push_cmd(ACT_PUT, 2'd0, 8'hFF);
        push_cmd(ACT_PUT, 2'd0, 8'h41);
        push_cmd(ACT_PUT, 2'd0, CH_BACKSPACE);
        push_cmd(ACT_PUT, 2'd0, CH_BACKSPACE);
        push_cmd(ACT_PUT, 2'd0, CH_BACKSPACE);
        push_cmd(ACT_PUT, 2'd0, CH_BACKSPACE);
        push_cmd(ACT_PUT, 2'd0, CH_NEWLINE);
        push_cmd(ACT_PUT, 2'd0, CH_NEWLINE);
        push_cmd(ACT_UP, 2'd0, 8'h00);
        push_cmd(ACT_DOWN, 2'd0, 8'hFF);
        push_cmd(ACT_DOWN, 2'd0, 8'h00);
        push_cmd(ACT_UP, 2'd0, 8'h00);
        push_cmd(ACT_UP, 2'd0, 8'h00);
        push_cmd(2'd3, 2'd0, 8'h41);
        push_cmd(2'd3, 2'd3, 8'hFF);
        push_cmd(ACT_PUT, 2'd3, 8'h41);
        push_cmd(ACT_DOWN, 2'd3, 8'h00);
        push_cmd(ACT_PUT, 2'd1, CH_NEWLINE);
        push_cmd(ACT_PUT, 2'd1, 8'h7E);
        push_cmd(ACT_PUT, 2'd2, 8'h5A);
        push_cmd(ACT_UP, 2'd2, 8'h00);
        push_cmd(ACT_DOWN, 2'd2, 8'h00);
        push_cmd(ACT_PUT, 2'd2, CH_BACKSPACE);

        run_phase(8'hFF, 1'b0);
        run_phase(8'h00, 1'b1);
        run_phase(8'($urandom_range(1, 254)), 1'b0);

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
